// ===== sv/cirm_pkg.sv =====
// ----------------------------------------------------------------------------
// cirm_pkg: shared types for the CAN identifier rule matcher
// Holds the payload words, operation and verdict codes, and the structs that
// pass between the top level and the rule cells.
// ----------------------------------------------------------------------------
package cirm_pkg;

  localparam int ID_W  = 32;
  localparam int IDX_W = 4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_NEW     = 2'd0,
    VERDICT_FILTER  = 2'd1,
    VERDICT_DISCARD = 2'd2
  } verdict_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] rule_index;
    logic [ID_W-1:0]  rule_mask;
    logic [ID_W-1:0]  rule_filter;
    logic [ID_W-1:0]  msg_id;
    logic             loopback_ok;
  } in_word_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [IDX_W-1:0] matched_index;
  } out_word_t;

  // Rule write strobe for one cell.
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] mask;
    logic [ID_W-1:0] filter;
  } rule_wr_t;

  // Search token walking down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
  } token_t;

endpackage

// ===== sv/cirm_cell.sv =====
// ----------------------------------------------------------------------------
// cirm_cell: one rule slot of the matcher chain
// Stores a mask and filter, tests the passing token against them and hands
// the registered token to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module cirm_cell import cirm_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rule_wr_t wr_i,
  input  token_t   tok_i,
  output token_t   tok_o
);

  localparam logic [IDX_W-1:0] CellIdx = IDX_W'(INDEX);

  logic [ID_W-1:0] mask_q;
  logic [ID_W-1:0] filter_q;
  token_t          tok_q, tok_d;

  always_comb begin
    tok_d = tok_i;
    // First hit wins: later cells see hit set and pass it along.
    if (tok_i.valid && !tok_i.hit && ((tok_i.id & mask_q) == filter_q)) begin
      tok_d.hit = 1'b1;
      tok_d.idx = CellIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      filter_q <= '0;
      tok_q    <= '0;
    end else begin
      if (wr_i.en) begin
        mask_q   <= wr_i.mask;
        filter_q <= wr_i.filter;
      end
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/can_id_rule_match_unit.sv =====
// Rule write: takes effect at its accepting edge and returns no word.
// Evaluate: an id equal to new_rule_id skips the chain; any other id walks the cell chain,
// one register per cell; either verdict then passes the pending and output registers.
// Flow: no word is taken while a scan runs or a result is parked, so a new evaluate waits for
// the last one to leave the pending register; rule writes go back to back while neither holds.
// Reset: rst_ni clears every rule to mask 0 / filter 0 (match-all) and new_rule_id to 0.
// ----------------------------------------------------------------------------
// can_id_rule_match_unit: CAN identifier firewall rule matcher
// Classifies message identifiers against a table of mask/filter rules held in
// a chain of cells; the lowest-indexed matching rule wins, and a reserved
// identifier is routed to the new-rule path depending on the loopback test.
// ----------------------------------------------------------------------------
module can_id_rule_match_unit import cirm_pkg::*; #(
  parameter int RULE_COUNT = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input word channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  // result word channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  // configuration: new_rule_id
  input  logic            cfg_we_i,
  input  logic [ID_W-1:0] cfg_wdata_i
);

  // Configuration register.
  logic [ID_W-1:0] new_id_q;

  // Control: scan in flight, pending result, output register.
  logic      scan_q, scan_d;
  logic      pend_v_q, pend_v_d;
  out_word_t pend_q, pend_d;
  logic      out_v_q, out_v_d;
  out_word_t out_q, out_d;

  logic   in_acc;
  logic   eval_acc;
  logic   is_new;
  logic   out_load;
  token_t tok [RULE_COUNT+1];

  // Take one word at a time: hold off while a scan runs or a result is parked
  // ahead of the output register. A waiting output word does not block input.
  assign in_ready_o = !scan_q && !pend_v_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign eval_acc   = in_acc && (in_word_i.op == OP_EVAL);
  assign is_new     = (in_word_i.msg_id == new_id_q);

  // Launch a token into the head of the chain for ordinary identifiers.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = eval_acc && !is_new;
    tok[0].id    = in_word_i.msg_id;
  end

  // Build the chain: each cell owns one rule and advances the token by one.
  for (genvar i = 0; i < RULE_COUNT; i++) begin : g_cell
    rule_wr_t wr;

    always_comb begin
      wr.en     = in_acc && (in_word_i.op == OP_WRITE) &&
                  (32'(in_word_i.rule_index) == 32'(i));
      wr.mask   = in_word_i.rule_mask;
      wr.filter = in_word_i.rule_filter;
    end

    cirm_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  assign out_load = !out_v_q || out_ready_i;

  always_comb begin
    scan_d   = scan_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    out_d    = out_q;

    // Move the parked result into the output register when it is free.
    if (out_load) begin
      out_v_d  = pend_v_q;
      out_d    = pend_q;
      pend_v_d = 1'b0;
    end

    // Reserved identifier: skip the table entirely.
    if (eval_acc && is_new) begin
      pend_v_d             = 1'b1;
      pend_d.verdict       = in_word_i.loopback_ok ? VERDICT_NEW : VERDICT_DISCARD;
      pend_d.matched_index = '0;
    end

    if (tok[0].valid) begin
      scan_d = 1'b1;
    end

    // Token leaves the tail: the scan is over, park its verdict.
    if (tok[RULE_COUNT].valid) begin
      scan_d               = 1'b0;
      pend_v_d             = 1'b1;
      pend_d.verdict       = tok[RULE_COUNT].hit ? VERDICT_FILTER : VERDICT_DISCARD;
      pend_d.matched_index = tok[RULE_COUNT].hit ? tok[RULE_COUNT].idx : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_id_q <= '0;
      scan_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        new_id_q <= cfg_wdata_i;
      end
      scan_q   <= scan_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/cirm_checker.sv =====
// ----------------------------------------------------------------------------
// cirm_checker: port-level checks for the rule matcher
// Watches the top-level ports only; attached to every instance by bind.
// ----------------------------------------------------------------------------
module cirm_checker import cirm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // Hold the result word until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // An evaluate always holds in_ready_o low in the cycle after it is taken.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.op == OP_EVAL) |=> !in_ready_o)
    else $error("input taken while an evaluate is in flight");

  // Only the three verdict codes appear.
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.verdict == VERDICT_NEW) ||
                    (out_word_o.verdict == VERDICT_FILTER) ||
                    (out_word_o.verdict == VERDICT_DISCARD))
    else $error("illegal verdict code");

  // Index is zero unless a filter rule matched.
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.verdict != VERDICT_FILTER) |->
      (out_word_o.matched_index == '0))
    else $error("matched_index set without a filter hit");

endmodule

bind can_id_rule_match_unit cirm_checker u_cirm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
